// ===== rtl/ppdc_pkg.sv =====
// Types and constants shared by the PWM prescaler, period and duty calculator.
`timescale 1ns / 1ps
package ppdc_pkg;

  localparam int unsigned FREQ_W  = 32;
  localparam int unsigned DUTY_W  = 16;
  localparam int unsigned PSEL_W  = 3;
  localparam int unsigned TOP_W   = 15;
  localparam int unsigned SEQ_W   = 16;
  localparam int unsigned LIM_W   = TOP_W + FREQ_W;
  localparam int unsigned DIV_W   = 48;
  localparam int unsigned QUOT_W  = 15;
  localparam int unsigned PROD_W  = 2 * TOP_W;

  localparam logic [TOP_W-1:0] TOP_MIN    = 15'd3;
  localparam logic [TOP_W-1:0] HUNDRED_Q8 = 15'd25600;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_DIV_TOP,
    ST_TOP_SET,
    ST_MUL,
    ST_CMP_START,
    ST_DIV_CMP,
    ST_CMP_SET,
    ST_DONE
  } ppdc_state_e;

  typedef struct packed {
    logic load;
    logic search_step;
    logic top_clamp;
    logic div_start;
    logic div_src_prod;
    logic div_step;
    logic top_set;
    logic mul;
    logic cmp_set;
    logic out_load;
  } ppdc_cmd_t;

  typedef struct packed {
    logic freq_zero;
    logic fits;
    logic p_last;
    logic div_last;
  } ppdc_sts_t;

endpackage

// ===== rtl/ppdc_ifs.sv =====
// Valid/ready channel interfaces for request and result transfers.
`timescale 1ns / 1ps
interface ppdc_in_if
  import ppdc_pkg::*;
();
  logic                     valid;
  logic                     ready;
  logic [FREQ_W-1:0]        freq_q8;
  logic signed [DUTY_W-1:0] duty_q8;

  modport source (output valid, freq_q8, duty_q8, input ready);
  modport sink   (input valid, freq_q8, duty_q8, output ready);
endinterface

interface ppdc_out_if
  import ppdc_pkg::*;
();
  logic              valid;
  logic              ready;
  logic              accepted;
  logic [PSEL_W-1:0] prescale_sel;
  logic [TOP_W-1:0]  period_top;
  logic [TOP_W-1:0]  compare_val;
  logic [SEQ_W-1:0]  seq_word;

  modport source (output valid, accepted, prescale_sel, period_top, compare_val, seq_word,
                  input ready);
  modport sink   (input valid, accepted, prescale_sel, period_top, compare_val, seq_word,
                  output ready);
endinterface

// ===== rtl/pwm_prescaler_period_duty_calc.sv =====
// A zero-frequency request goes straight from the search to the result; otherwise the
// period is clamped (p = PRESCALE_MAX) or divided before the compare value is divided.
// One request is handled at a time; the next request is taken the cycle
// after the result is loaded, while that result may still wait in the output register.
// One compare per prescaler, then the shared 15-step divider for period and compare value.
// Reset (async, active low) returns the controller to idle and empties the output register.
`timescale 1ns / 1ps
module pwm_prescaler_period_duty_calc
  import ppdc_pkg::*;
#(
  parameter int unsigned BASE_CLOCK_HZ = 16000000,
  parameter int unsigned TOP_MAX       = 32767,
  parameter int unsigned PRESCALE_MAX  = 7
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  ppdc_in_if.sink    in_i,
  ppdc_out_if.source out_o
);

  ppdc_cmd_t cmd;
  ppdc_sts_t sts;

  ppdc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  ppdc_dp #(
    .BASE_CLOCK_HZ (BASE_CLOCK_HZ),
    .TOP_MAX       (TOP_MAX),
    .PRESCALE_MAX  (PRESCALE_MAX)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .freq_i         (in_i.freq_q8),
    .duty_i         (in_i.duty_q8),
    .accepted_o     (out_o.accepted),
    .prescale_sel_o (out_o.prescale_sel),
    .period_top_o   (out_o.period_top),
    .compare_val_o  (out_o.compare_val),
    .seq_word_o     (out_o.seq_word)
  );

endmodule

// ===== rtl/ppdc_div.sv =====
// Restoring divider, one quotient bit per cycle while step_i is high, quotient known to fit 15 bits.
`timescale 1ns / 1ps
module ppdc_div
  import ppdc_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic              step_i,
  input  logic [DIV_W-1:0]  dividend_i,
  input  logic [FREQ_W-1:0] divisor_i,
  output logic [QUOT_W-1:0] quot_o,
  output logic              last_o
);

  localparam int unsigned CNT_W = $clog2(QUOT_W);

  logic [DIV_W-1:0]  rem_q, rem_d;
  logic [DIV_W-1:0]  dsh_q, dsh_d;
  logic [QUOT_W-1:0] quot_q, quot_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              ge;

  assign ge = rem_q >= dsh_q;

  always_comb begin
    rem_d  = rem_q;
    dsh_d  = dsh_q;
    quot_d = quot_q;
    cnt_d  = cnt_q;
    if (start_i) begin
      rem_d  = dividend_i;
      dsh_d  = DIV_W'(divisor_i) << (QUOT_W - 1);
      quot_d = '0;
      cnt_d  = CNT_W'(QUOT_W - 1);
    end else if (step_i) begin
      if (ge) begin
        rem_d = rem_q - dsh_q;
      end
      dsh_d  = dsh_q >> 1;
      quot_d = {quot_q[QUOT_W-2:0], ge};
      cnt_d  = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    dsh_q  <= dsh_d;
    quot_q <= quot_d;
  end

  assign quot_o = quot_q;
  assign last_o = cnt_q == '0;

endmodule

// ===== rtl/ppdc_dp.sv =====
// Datapath: operand registers, prescaler search, multiplier, divider and result register.
`timescale 1ns / 1ps
module ppdc_dp
  import ppdc_pkg::*;
#(
  parameter int unsigned BASE_CLOCK_HZ = 16000000,
  parameter int unsigned TOP_MAX       = 32767,
  parameter int unsigned PRESCALE_MAX  = 7
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  ppdc_cmd_t                cmd_i,
  output ppdc_sts_t                sts_o,
  input  logic [FREQ_W-1:0]        freq_i,
  input  logic signed [DUTY_W-1:0] duty_i,
  output logic                     accepted_o,
  output logic [PSEL_W-1:0]        prescale_sel_o,
  output logic [TOP_W-1:0]         period_top_o,
  output logic [TOP_W-1:0]         compare_val_o,
  output logic [SEQ_W-1:0]         seq_word_o
);

  localparam int unsigned BASE_W = $clog2(BASE_CLOCK_HZ + 1);
  localparam int unsigned NUM_W  = BASE_W + 8;
  localparam int unsigned P_W    = $clog2(PRESCALE_MAX + 1);
  localparam logic [TOP_W-1:0] TopMax = TOP_W'(TOP_MAX);

  logic [FREQ_W-1:0] freq_q;
  logic [LIM_W-1:0]  lim_q;
  logic [TOP_W-1:0]  duty_q, duty_d;
  logic              zero_q;
  logic [BASE_W-1:0] base_q;
  logic [P_W-1:0]    p_q;
  logic [TOP_W-1:0]  top_q;
  logic [PROD_W-1:0] prod_q;
  logic [TOP_W-1:0]  cmp_q;

  logic              out_acc_q;
  logic [PSEL_W-1:0] out_p_q;
  logic [TOP_W-1:0]  out_top_q;
  logic [TOP_W-1:0]  out_cmp_q;
  logic [SEQ_W-1:0]  out_seq_q;

  logic [NUM_W-1:0]  num;
  logic [DIV_W-1:0]  div_dividend;
  logic [FREQ_W-1:0] div_divisor;
  logic [QUOT_W-1:0] quot;
  logic              div_last;

  // Shifted base clock in Q.8, the dividend of the period quotient
  assign num = {base_q, 8'd0};

  always_comb begin
    if (duty_i[DUTY_W-1]) begin
      duty_d = '0;
    end else if (duty_i[DUTY_W-2:0] > HUNDRED_Q8) begin
      duty_d = HUNDRED_Q8;
    end else begin
      duty_d = duty_i[DUTY_W-2:0];
    end
  end

  assign div_dividend = cmd_i.div_src_prod ? DIV_W'(prod_q) : DIV_W'(num);
  assign div_divisor  = cmd_i.div_src_prod ? FREQ_W'(HUNDRED_Q8) : freq_q;

  ppdc_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .step_i     (cmd_i.div_step),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .quot_o     (quot),
    .last_o     (div_last)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      freq_q <= freq_i;
      lim_q  <= LIM_W'(TopMax) * LIM_W'(freq_i);
      duty_q <= duty_d;
      zero_q <= freq_i == '0;
      base_q <= BASE_W'(BASE_CLOCK_HZ);
      p_q    <= '0;
    end else if (cmd_i.search_step) begin
      base_q <= base_q >> 1;
      p_q    <= p_q + 1'b1;
    end
    if (cmd_i.top_clamp) begin
      top_q <= TopMax;
    end else if (cmd_i.top_set) begin
      top_q <= (quot < TOP_MIN) ? TOP_MIN : quot;
    end
    if (cmd_i.mul) begin
      prod_q <= PROD_W'(top_q) * PROD_W'(duty_q);
    end
    if (cmd_i.cmp_set) begin
      cmp_q <= (quot > top_q) ? top_q : quot;
    end
    if (cmd_i.out_load) begin
      out_acc_q <= !zero_q;
      if (zero_q) begin
        out_p_q   <= '0;
        out_top_q <= '0;
        out_cmp_q <= '0;
        out_seq_q <= '0;
      end else begin
        out_p_q   <= PSEL_W'(p_q);
        out_top_q <= top_q;
        out_cmp_q <= cmp_q;
        out_seq_q <= {1'b1, cmp_q};
      end
    end
  end

  assign sts_o.freq_zero = zero_q;
  assign sts_o.fits      = LIM_W'(num) <= lim_q;
  assign sts_o.p_last    = p_q == P_W'(PRESCALE_MAX);
  assign sts_o.div_last  = div_last;

  assign accepted_o     = out_acc_q;
  assign prescale_sel_o = out_p_q;
  assign period_top_o   = out_top_q;
  assign compare_val_o  = out_cmp_q;
  assign seq_word_o     = out_seq_q;

endmodule

// ===== rtl/ppdc_ctrl.sv =====
// Controller: sequences search, divisions and multiply, and owns the handshakes.
`timescale 1ns / 1ps
module ppdc_ctrl
  import ppdc_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  input  ppdc_sts_t sts_i,
  output ppdc_cmd_t cmd_o
);

  ppdc_state_e state_q, state_d;
  logic        out_valid_q, out_valid_d;
  logic        out_free;

  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_SEARCH;
      end
      ST_SEARCH: begin
        if (sts_i.freq_zero) begin
          state_d = ST_DONE;
        end else if (sts_i.fits) begin
          state_d = ST_DIV_TOP;
        end else if (sts_i.p_last) begin
          state_d = ST_MUL;
        end
      end
      ST_DIV_TOP: begin
        if (sts_i.div_last) state_d = ST_TOP_SET;
      end
      ST_TOP_SET:   state_d = ST_MUL;
      ST_MUL:       state_d = ST_CMP_START;
      ST_CMP_START: state_d = ST_DIV_CMP;
      ST_DIV_CMP: begin
        if (sts_i.div_last) state_d = ST_CMP_SET;
      end
      ST_CMP_SET:   state_d = ST_DONE;
      ST_DONE: begin
        if (out_free) state_d = ST_IDLE;
      end
      default:      state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_d = out_valid_q && !out_ready_i;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      ST_SEARCH: begin
        if (!sts_i.freq_zero) begin
          if (sts_i.fits) begin
            cmd_o.div_start = 1'b1;
          end else if (sts_i.p_last) begin
            cmd_o.top_clamp = 1'b1;
          end else begin
            cmd_o.search_step = 1'b1;
          end
        end
      end
      ST_DIV_TOP:   cmd_o.div_step = 1'b1;
      ST_TOP_SET:   cmd_o.top_set = 1'b1;
      ST_MUL:       cmd_o.mul = 1'b1;
      ST_CMP_START: begin
        cmd_o.div_start    = 1'b1;
        cmd_o.div_src_prod = 1'b1;
      end
      ST_DIV_CMP:   cmd_o.div_step = 1'b1;
      ST_CMP_SET:   cmd_o.cmp_set = 1'b1;
      ST_DONE: begin
        // hold until the result register is free, then load it
        if (out_free) begin
          cmd_o.out_load = 1'b1;
          out_valid_d    = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ===== test/tb_top.sv =====
// Self-checking testbench for the PWM prescaler, period and duty calculator.
`timescale 1ns / 1ps
module tb_top
  import ppdc_pkg::*;
();

  localparam longint unsigned CLK_HZ    = 16000000;
  localparam longint unsigned TOP_LIMIT = 32767;
  localparam int unsigned     PSEL_LAST = 7;
  localparam longint unsigned TOP_FLOOR = 3;
  localparam longint unsigned PCT_FULL  = 25600;
  localparam int unsigned     STALL_LIMIT = 4000;
  localparam int unsigned     SETTLE_CYCLES = 60;

  typedef struct packed {
    logic              accepted;
    logic [PSEL_W-1:0] psel;
    logic [TOP_W-1:0]  top;
    logic [TOP_W-1:0]  cmp;
    logic [SEQ_W-1:0]  seq;
  } pwm_setting_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  ppdc_in_if  in_if ();
  ppdc_out_if out_if ();

  pwm_prescaler_period_duty_calc u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  always #5 clk_i = ~clk_i;

  pwm_setting_t setting_q[$];
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  int unsigned n_errors  = 0;
  int unsigned n_sent    = 0;
  int unsigned n_checked = 0;
  int unsigned n_zero    = 0;
  int unsigned n_clamped = 0;
  int unsigned n_floor   = 0;
  int unsigned stall_cnt = 0;

  // Work out the prescaler, period top and compare value for one request.
  function automatic pwm_setting_t calc_pwm_setting(logic [FREQ_W-1:0] freq,
                                                    logic signed [DUTY_W-1:0] duty);
    pwm_setting_t     r;
    longint unsigned  num;
    longint unsigned  top;
    longint unsigned  cmp;
    longint unsigned  duty_c;
    int unsigned      psel;
    bit               found;
    r = '0;
    if (freq == '0) return r;
    found = 1'b0;
    top   = 0;
    psel  = PSEL_LAST;
    for (int unsigned p = 0; p <= PSEL_LAST; p++) begin
      num = (CLK_HZ >> p) << 8;
      if (!found && num <= TOP_LIMIT * longint'(freq)) begin
        top   = num / longint'(freq);
        psel  = p;
        found = 1'b1;
      end
    end
    if (!found) begin
      psel = PSEL_LAST;
      top  = TOP_LIMIT;
    end
    if (top < TOP_FLOOR) top = TOP_FLOOR;
    if (duty < 0) begin
      duty_c = 0;
    end else if (longint'(duty) > PCT_FULL) begin
      duty_c = PCT_FULL;
    end else begin
      duty_c = longint'(duty);
    end
    cmp = (top * duty_c) / PCT_FULL;
    if (cmp > top) cmp = top;
    r.accepted = 1'b1;
    r.psel     = psel[PSEL_W-1:0];
    r.top      = top[TOP_W-1:0];
    r.cmp      = cmp[TOP_W-1:0];
    r.seq      = {1'b1, cmp[TOP_W-1:0]};
    return r;
  endfunction

  // Drop valid and hold it low for one cycle so a later raise lands on a new edge.
  task automatic release_request();
    in_if.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic send_request(logic [FREQ_W-1:0] freq, logic signed [DUTY_W-1:0] duty);
    if ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk_i);
    end
    in_if.valid   <= 1'b1;
    in_if.freq_q8 <= freq;
    in_if.duty_q8 <= duty;
    do @(posedge clk_i); while (!(in_if.valid && in_if.ready));
    setting_q.push_back(calc_pwm_setting(freq, duty));
    n_sent++;
  endtask

  task automatic wait_drained();
    release_request();
    while (setting_q.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [FREQ_W-1:0] rand_freq();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 3)  return '0;
    if (pick < 13) return FREQ_W'($urandom_range(1, 2000));
    if (pick < 23) return FREQ_W'($urandom());
    if (pick < 30) return FREQ_W'($urandom_range(32'h4000_0000, 32'hFFFF_FFFF));
    return {FREQ_W'($urandom_range(1, 200000)) << 8} | FREQ_W'($urandom_range(0, 255));
  endfunction

  function automatic logic signed [DUTY_W-1:0] rand_duty();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 10) return DUTY_W'($urandom());
    if (pick < 20) return DUTY_W'($urandom_range(25600, 32767));
    return DUTY_W'($urandom_range(0, 25600));
  endfunction

  task automatic test_directed();
    logic [FREQ_W-1:0]        f_list[$];
    logic signed [DUTY_W-1:0] d_list[$];
    send_idle_pct = 0;
    recv_idle_pct = 0;
    // zero frequency, lowest and highest codes, clamp and prescaler boundaries, tiny tops
    f_list = '{32'd0, 32'hFFFF_FFFF, 32'd1, 32'd976, 32'd977, 32'd125003, 32'd125004,
               32'd1000 << 8, 32'h8000_0000, 32'd1170285714, 32'd1365333333,
               32'd50000 << 8, 32'd0};
    d_list = '{16'sh8000, 16'sh7FFF, 16'sd0, 16'sd25600, 16'sd25601, 16'sd12800,
               -16'sd1, 16'sd128, 16'sd256, 16'sd25599, 16'sd1, 16'sh4000, 16'sd25600};
    foreach (f_list[i]) send_request(f_list[i], d_list[i]);
    foreach (d_list[i]) if (i < 8) send_request(32'd20000 << 8, d_list[i]);
    wait_drained();
  endtask

  task automatic test_random_traffic(int sidle, int ridle, int unsigned n_items);
    send_idle_pct = sidle;
    recv_idle_pct = ridle;
    repeat (n_items) send_request(rand_freq(), rand_duty());
    release_request();
  endtask

  // Stop sending until every outstanding result has been taken, then resume.
  task automatic test_drain_pause();
    send_idle_pct = 0;
    recv_idle_pct = 30;
    repeat (4) begin
      repeat (10) send_request(rand_freq(), rand_duty());
      wait_drained();
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic check_field(string name, longint unsigned exp_v, longint unsigned act_v);
    if (exp_v != act_v) begin
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
      n_errors++;
    end
  endtask

  always @(posedge clk_i) begin
    pwm_setting_t exp_s;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (setting_q.size() == 0) begin
        $display("%0t ns: result transfer with nothing expected, actual top %0d cmp %0d",
                 $time, out_if.period_top, out_if.compare_val);
        n_errors++;
      end else begin
        exp_s = setting_q.pop_front();
        check_field("accepted", 64'(exp_s.accepted), 64'(out_if.accepted));
        check_field("prescale_sel", 64'(exp_s.psel), 64'(out_if.prescale_sel));
        check_field("period_top", 64'(exp_s.top), 64'(out_if.period_top));
        check_field("compare_val", 64'(exp_s.cmp), 64'(out_if.compare_val));
        check_field("seq_word", 64'(exp_s.seq), 64'(out_if.seq_word));
        n_checked++;
        if (!exp_s.accepted) n_zero++;
        if (exp_s.accepted && exp_s.psel == PSEL_LAST && exp_s.top == TOP_LIMIT) n_clamped++;
        if (exp_s.accepted && exp_s.top == TOP_FLOOR) n_floor++;
      end
    end
  end

  // Abort when no transfer happens on either channel for too long.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
        stall_cnt <= 0;
      end else if (stall_cnt + 1 >= STALL_LIMIT) begin
        $display("%0t ns: no transfer for %0d cycles, %0d results outstanding",
                 $time, STALL_LIMIT, setting_q.size());
        $display("FAIL pwm_prescaler_period_duty_calc");
        $finish;
      end else begin
        stall_cnt <= stall_cnt + 1;
      end
    end
  end

  initial begin
    rst_ni        <= 1'b0;
    in_if.valid   <= 1'b0;
    in_if.freq_q8 <= '0;
    in_if.duty_q8 <= '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_random_traffic(14, 82, 520);
    test_random_traffic(82, 14, 520);
    test_random_traffic(0, 0, 520);
    test_drain_pause();

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (setting_q.size() != 0) begin
      $display("%0t ns: %0d expected results never arrived", $time, setting_q.size());
      n_errors++;
    end
    $display("Sent %0d requests, checked %0d results, %0d errors.",
             n_sent, n_checked, n_errors);
    $display("Covered %0d zero-frequency rejects, %0d clamped periods, %0d floored tops.",
             n_zero, n_clamped, n_floor);
    if (n_errors == 0) begin
      $display("PASS pwm_prescaler_period_duty_calc");
    end else begin
      $display("FAIL pwm_prescaler_period_duty_calc");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/ppdc_pkg.sv
rtl/ppdc_ifs.sv
rtl/ppdc_div.sv
rtl/ppdc_dp.sv
rtl/ppdc_ctrl.sv
rtl/pwm_prescaler_period_duty_calc.sv
test/tb_top.sv
